// ----- hw/rtl/ssg_pkg.sv -----
// Shared types, register map and reset values for the servo sweep generator.
package ssg_pkg;

	// Item kinds carried on the input tuser
	typedef enum logic [1:0] {
		OP_TICK       = 2'd0,
		OP_LOAD_STEPS = 2'd1,
		OP_LOAD_WIDTH = 2'd2
	} ssg_opcode_t;

	// Register indexes (byte address is 4 * index)
	localparam logic [2:0] REG_TICK_DIVIDE = 3'd0;
	localparam logic [2:0] REG_STEP_SIZE   = 3'd1;
	localparam logic [2:0] REG_STEP_LIMIT  = 3'd2;
	localparam logic [2:0] REG_UPPER_BOUND = 3'd3;
	localparam logic [2:0] REG_LOWER_BOUND = 3'd4;

	// Register reset values
	localparam logic [9:0]  RST_TICK_DIVIDE = 10'd10;
	localparam logic [11:0] RST_STEP_SIZE   = 12'd100;
	localparam logic [7:0]  RST_STEP_LIMIT  = 8'd24;
	localparam logic [15:0] RST_UPPER_BOUND = 16'd2100;
	localparam logic [15:0] RST_LOWER_BOUND = 16'd900;

	// Sweep state reset values
	localparam logic [10:0] RST_TICK_COUNT   = 11'd0;
	localparam logic [7:0]  RST_STEPS_DONE   = 8'd24;
	localparam logic [15:0] RST_WIDTH_NOW    = 16'd900;
	localparam logic        RST_DIRECTION_UP = 1'b1;

	// Configuration seen by the sweep core
	typedef struct packed {
		logic [9:0]  tick_divide;
		logic [11:0] step_size;
		logic [7:0]  step_limit;
		logic [15:0] upper_bound;
		logic [15:0] lower_bound;
	} ssg_cfg_t;

	// One result; pulse_width sits in the lowest bits
	typedef struct packed {
		logic        unfinished;
		logic        moving_up;
		logic [15:0] pulse_width;
	} ssg_result_t;

	localparam int unsigned RESULT_W = $bits(ssg_result_t);
	localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ----- hw/rtl/servo_sweep_generator_top.sv -----
// Servo sweep generator: tick/load stream in, pulse width stream out, APB registers.
// Takes one request per clock while s_axis_tready is high and returns one result
// per request from a registered output; the whole update (divider compare,
// saturating add or subtract, bound compare) sits between the input handshake
// and the output register. A two-entry output buffer lets the input take one
// more request while the output side stalls; s_axis_tready drops only when
// both entries are full. Registers are written with APB at byte address
// 4*index and should only be changed while no result is pending.
module servo_sweep_generator_top (
	input  logic        clk,
	input  logic        arst_n,
	// input requests
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] load_value
	input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
	// results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [ssg_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // [15:0] pulse_width,
	                                                      // [16] moving_up,
	                                                      // [17] unfinished, rest 0
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	ssg_pkg::ssg_cfg_t    cfg_q;
	ssg_pkg::ssg_result_t result;
	ssg_pkg::ssg_result_t out_q, skid_q;
	logic                 out_valid_q, skid_valid_q;
	logic                 in_fire;
	logic                 cfg_write;
	logic                 out_load;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_divide <= ssg_pkg::RST_TICK_DIVIDE;
			cfg_q.step_size   <= ssg_pkg::RST_STEP_SIZE;
			cfg_q.step_limit  <= ssg_pkg::RST_STEP_LIMIT;
			cfg_q.upper_bound <= ssg_pkg::RST_UPPER_BOUND;
			cfg_q.lower_bound <= ssg_pkg::RST_LOWER_BOUND;
		end else if (cfg_write) begin
			unique case (paddr[4:2])
				ssg_pkg::REG_TICK_DIVIDE: cfg_q.tick_divide <= pwdata[9:0];
				ssg_pkg::REG_STEP_SIZE:   cfg_q.step_size   <= pwdata[11:0];
				ssg_pkg::REG_STEP_LIMIT:  cfg_q.step_limit  <= pwdata[7:0];
				ssg_pkg::REG_UPPER_BOUND: cfg_q.upper_bound <= pwdata[15:0];
				ssg_pkg::REG_LOWER_BOUND: cfg_q.lower_bound <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back
	always_comb begin
		unique case (paddr[4:2])
			ssg_pkg::REG_TICK_DIVIDE: prdata = {22'd0, cfg_q.tick_divide};
			ssg_pkg::REG_STEP_SIZE:   prdata = {20'd0, cfg_q.step_size};
			ssg_pkg::REG_STEP_LIMIT:  prdata = {24'd0, cfg_q.step_limit};
			ssg_pkg::REG_UPPER_BOUND: prdata = {16'd0, cfg_q.upper_bound};
			ssg_pkg::REG_LOWER_BOUND: prdata = {16'd0, cfg_q.lower_bound};
			default:                  prdata = 32'd0;
		endcase
	end

	// Input handshake: blocked only when both output entries hold results
	assign s_axis_tready = !skid_valid_q;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_load      = !out_valid_q || m_axis_tready;

	ssg_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_fire  (in_fire),
		.opcode     (s_axis_tuser),
		.load_value (s_axis_tdata),
		.cfg        (cfg_q),
		.result     (result)
	);

	// Output buffer occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q  <= skid_valid_q || in_fire;
			skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output buffer data
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= skid_valid_q ? skid_q : result;
		end else if (in_fire) begin
			skid_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(ssg_pkg::OUT_TDATA_W - ssg_pkg::RESULT_W){1'b0}}, out_q};

endmodule

// ----- hw/rtl/ssg_core.sv -----
// Sweep state and combinational next-state update for one request.
module ssg_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_fire,
	input  logic [1:0]            opcode,
	input  logic [15:0]           load_value,
	input  ssg_pkg::ssg_cfg_t     cfg,
	output ssg_pkg::ssg_result_t  result
);

	logic [10:0] tick_count_q, tick_count_d;
	logic [7:0]  steps_done_q, steps_done_d;
	logic [15:0] width_now_q,  width_now_d;
	logic        direction_up_q, direction_up_d;

	logic        reached;
	logic        step_en;
	logic [16:0] sum_up;
	logic [15:0] width_up;
	logic [15:0] width_down;
	logic [8:0]  steps_plus_one;

	// Divider compare, saturating add and subtract
	always_comb begin
		reached    = tick_count_q >= {1'b0, cfg.tick_divide};
		step_en    = reached && (steps_done_q < cfg.step_limit);
		sum_up     = {1'b0, width_now_q} + {5'b0, cfg.step_size};
		width_up   = sum_up[16] ? 16'hFFFF : sum_up[15:0];
		width_down = (width_now_q >= {4'b0, cfg.step_size})
			? (width_now_q - {4'b0, cfg.step_size}) : 16'd0;
	end

	// Next state for the request being taken
	always_comb begin
		tick_count_d   = tick_count_q;
		steps_done_d   = steps_done_q;
		width_now_d    = width_now_q;
		direction_up_d = direction_up_q;
		case (ssg_pkg::ssg_opcode_t'(opcode))
			ssg_pkg::OP_TICK: begin
				tick_count_d = reached ? 11'd1 : (tick_count_q + 11'd1);
				if (step_en) begin
					steps_done_d = steps_done_q + 8'd1;
					if (direction_up_q) begin
						width_now_d    = width_up;
						direction_up_d = !(width_up >= cfg.upper_bound);
					end else begin
						width_now_d    = width_down;
						direction_up_d = width_down <= cfg.lower_bound;
					end
				end
			end
			ssg_pkg::OP_LOAD_STEPS: begin
				steps_done_d = load_value[7:0];
			end
			ssg_pkg::OP_LOAD_WIDTH: begin
				width_now_d = load_value;
			end
			default: begin
				// unused code: state left as it is
			end
		endcase
	end

	// Result reflects the state after this request
	always_comb begin
		steps_plus_one     = {1'b0, steps_done_d} + 9'd1;
		result.pulse_width = width_now_d;
		result.moving_up   = direction_up_d;
		result.unfinished  = steps_plus_one < {1'b0, cfg.step_limit};
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q   <= ssg_pkg::RST_TICK_COUNT;
			steps_done_q   <= ssg_pkg::RST_STEPS_DONE;
			width_now_q    <= ssg_pkg::RST_WIDTH_NOW;
			direction_up_q <= ssg_pkg::RST_DIRECTION_UP;
		end else if (item_fire) begin
			tick_count_q   <= tick_count_d;
			steps_done_q   <= steps_done_d;
			width_now_q    <= width_now_d;
			direction_up_q <= direction_up_d;
		end
	end

endmodule

// ----- hw/rtl/ssg_checker.sv -----
// Port-level checks for the servo sweep generator, bound to the top level.
module ssg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [ssg_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// Input is only held off when a result is already waiting
	a_ready_implies_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result pending");

	// A request taken into an empty output shows up the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> m_axis_tvalid)
		else $error("result missing after accepted request");

	// A width load is reported back unchanged
	a_width_load_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !m_axis_tvalid
			&& s_axis_tuser == ssg_pkg::OP_LOAD_WIDTH)
		|=> m_axis_tdata[15:0] == $past(s_axis_tdata))
		else $error("loaded width not reported");

	// A stalled result holds its data
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

endmodule

bind servo_sweep_generator_top ssg_checker u_ssg_checker (.*);
